/* design/scbsa_pkg.sv */
// Shared constants and types for the size-class slab allocator.
// Used by size_class_bitmap_slab_allocator; no dependencies.
`default_nettype none

package scbsa_pkg;

    localparam int POOL_BYTES     = 4096;
    localparam int MAX_POOLS      = 8;
    localparam int CLASS_COUNT    = 6;
    localparam int MIN_SLOT_BYTES = 16;
    localparam int MAX_SLOT_BYTES = 512;
    localparam int MIN_SHIFT      = $clog2(MIN_SLOT_BYTES);

    localparam int WORDS_PER_POOL = (POOL_BYTES / MIN_SLOT_BYTES + 63) / 64;
    localparam int BITMAP_DEPTH   = MAX_POOLS * WORDS_PER_POOL;
    localparam int BITMAP_WIDTH   = 64;

    localparam int ADDR_W   = 15;
    localparam int SIZE_W   = 10;
    localparam int OFFSET_W = $clog2(POOL_BYTES);
    localparam int POOL_W   = $clog2(MAX_POOLS);
    localparam int CNT_W    = $clog2(MAX_POOLS + 1);
    localparam int WORD_W   = $clog2(WORDS_PER_POOL);
    localparam int SLOT_W   = $clog2(POOL_BYTES / MIN_SLOT_BYTES);
    localparam int BIT_W    = 6;
    localparam int CLASS_W  = 3;

    typedef enum logic [1:0] {
        STATUS_DONE         = 2'd0,
        STATUS_NO_SPACE     = 2'd1,
        STATUS_FREE_IGNORED = 2'd2,
        STATUS_BAD_SIZE     = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

/* design/scbsa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module scbsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/size_class_bitmap_slab_allocator.sv */
// Top level of the size-class bitmap slab allocator: sequencer, pool tags, output register.
// Depends on scbsa_pkg and scbsa_ram (slot bitmap memory).
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  in      | in_valid  | in_stall  | opcode, request_size, free_address
//  out     | out_valid | out_stall | slot_address, status
//
// One item at a time. A bad size or an ignored free goes straight to the result state.
// Free: tag check and bitmap read, then write back, then result.
// Allocate: a scan over the pools in use, reading the bitmap words of each pool of
// the class in turn through the one-word-per-cycle read port of the bitmap memory;
// a miss in every pool ends the scan in either the result (no space) or a fill of
// the new pool's WORDS_PER_POOL bitmap words and then the result.
// Reset clears pool count, pool tags and control; the bitmap needs no clear,
// since a pool's words are written when the pool is claimed.
// The output register holds a result under out_stall while the next item is taken.
`default_nettype none

module size_class_bitmap_slab_allocator
    import scbsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              opcode,
    input  wire logic [SIZE_W-1:0] request_size,
    input  wire logic [ADDR_W-1:0] free_address,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [ADDR_W-1:0] slot_address,
    output logic      [1:0]        status
);

    localparam int RAM_AW = POOL_W + WORD_W;
    localparam int NW_W   = WORD_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_CLAIM,
        ST_FREE_WR,
        ST_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    pools_in_use_reg, pools_in_use_next;
    logic [CLASS_W-1:0]  pool_tag_reg [MAX_POOLS];
    logic                tag_we;
    logic [CLASS_W-1:0]  cls_reg, cls_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;      // pools still to visit
    logic [POOL_W-1:0]   pool_reg, pool_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;        // bit to set on a free
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   slot_address_reg, slot_address_next;
    status_t             status_reg, status_next;

    // bitmap memory ports
    logic                    ram_we, ram_re;
    logic [RAM_AW-1:0]       ram_waddr, ram_raddr;
    logic [BITMAP_WIDTH-1:0] ram_wdata, ram_rdata;

    scbsa_ram #(
        .WIDTH(BITMAP_WIDTH),
        .DEPTH(BITMAP_DEPTH)
    ) u_bitmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // lowest set bit: first nonzero byte, then first bit within it
    function automatic logic [BIT_W-1:0] lowest_set(input logic [BITMAP_WIDTH-1:0] w);
        logic [2:0] byte_sel;
        logic [2:0] bit_sel;
        logic [7:0] b;
        byte_sel = 3'd7;
        for (int i = 7; i >= 0; i--)
        begin
            if (w[i*8 +: 8] != 8'd0)
            begin
                byte_sel = 3'(i);
            end
        end
        b = w[byte_sel*8 +: 8];
        bit_sel = 3'd7;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i])
            begin
                bit_sel = 3'(i);
            end
        end
        return {byte_sel, bit_sel};
    endfunction

    wire in_accept  = in_valid && !in_stall;
    wire out_free   = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // smallest class that holds the request
    logic [CLASS_W-1:0] req_cls;
    always_comb
    begin
        req_cls = CLASS_W'(CLASS_COUNT - 1);
        for (int i = CLASS_COUNT - 1; i >= 0; i--)
        begin
            if (request_size <= SIZE_W'(MIN_SLOT_BYTES << i))
            begin
                req_cls = CLASS_W'(i);
            end
        end
    end
    wire bad_size = (request_size == '0) || (request_size > SIZE_W'(MAX_SLOT_BYTES));

    // per-class slot and word counts for the class under search
    logic [SLOT_W:0] class_slots;
    logic [SLOT_W:0] nw_full;
    logic [NW_W-1:0] class_words;
    assign class_slots = (SLOT_W+1)'(POOL_BYTES / MIN_SLOT_BYTES) >> cls_reg;
    assign nw_full     = (class_slots + (SLOT_W+1)'(63)) >> 6;
    assign class_words = nw_full[NW_W-1:0];

    // free request decode
    logic [POOL_W-1:0]   fr_pool;
    logic [OFFSET_W-1:0] fr_offset;
    logic [OFFSET_W-1:0] fr_mask;
    logic [SLOT_W-1:0]   fr_slot;
    logic [CLASS_W-1:0]  tag_rd;
    logic [POOL_W-1:0]   tag_idx;
    logic [POOL_W-1:0]   scan_idx;
    logic [CNT_W-1:0]    scan_dec;

    assign fr_pool   = free_address[OFFSET_W +: POOL_W];
    assign fr_offset = free_address[OFFSET_W-1:0];
    assign scan_dec  = scan_reg - CNT_W'(1);
    assign scan_idx  = scan_dec[POOL_W-1:0];
    assign tag_idx   = (state_reg == ST_IDLE) ? fr_pool : scan_idx;
    assign tag_rd    = pool_tag_reg[tag_idx];
    assign fr_mask   = (OFFSET_W'(MIN_SLOT_BYTES) << tag_rd) - OFFSET_W'(1);
    assign fr_slot   = SLOT_W'(fr_offset >> (MIN_SHIFT + int'(tag_rd)));

    wire fr_bad = ({1'b0, fr_pool} >= pools_in_use_reg)
               || (tag_rd >= CLASS_W'(CLASS_COUNT))
               || ((fr_offset & fr_mask) != '0);

    // bitmap word check during the scan
    logic [BIT_W-1:0]  hit_bit;
    logic [SLOT_W-1:0] hit_slot;
    logic [NW_W-1:0]   word_inc;
    assign hit_bit  = lowest_set(ram_rdata);
    assign hit_slot = {word_reg, hit_bit};
    assign word_inc = {1'b0, word_reg} + NW_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        pools_in_use_next = pools_in_use_reg;
        tag_we            = 1'b0;
        cls_next          = cls_reg;
        scan_next         = scan_reg;
        pool_next         = pool_reg;
        word_next         = word_reg;
        bit_next          = bit_reg;
        res_addr_next     = res_addr_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg;
        slot_address_next = slot_address_reg;
        status_next       = status_reg;
        ram_we            = 1'b0;
        ram_waddr         = {pool_reg, word_reg};
        ram_wdata         = '1;
        ram_re            = 1'b0;
        ram_raddr         = {pool_reg, word_reg};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                res_addr_next = '0;
                if (in_accept)
                begin
                    if (opcode == OP_ALLOC)
                    begin
                        if (bad_size)
                        begin
                            res_status_next = STATUS_BAD_SIZE;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            cls_next   = req_cls;
                            scan_next  = pools_in_use_reg;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (fr_bad)
                    begin
                        res_status_next = STATUS_FREE_IGNORED;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        // read the word now, set the bit next cycle
                        pool_next  = fr_pool;
                        word_next  = fr_slot[SLOT_W-1 -: WORD_W];
                        bit_next   = fr_slot[BIT_W-1:0];
                        ram_re     = 1'b1;
                        ram_raddr  = {fr_pool, fr_slot[SLOT_W-1 -: WORD_W]};
                        state_next = ST_FREE_WR;
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_reg == '0)
                begin
                    if (pools_in_use_reg >= CNT_W'(MAX_POOLS))
                    begin
                        res_status_next = STATUS_NO_SPACE;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        pool_next         = pools_in_use_reg[POOL_W-1:0];
                        pools_in_use_next = pools_in_use_reg + CNT_W'(1);
                        tag_we            = 1'b1;
                        word_next         = '0;
                        state_next        = ST_CLAIM;
                    end
                end
                else
                begin
                    scan_next = scan_dec;
                    if (tag_rd == cls_reg)
                    begin
                        pool_next  = scan_idx;
                        word_next  = '0;
                        ram_re     = 1'b1;
                        ram_raddr  = {scan_idx, WORD_W'(0)};
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (ram_rdata != '0)
                begin
                    if ({1'b0, hit_slot} < class_slots)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = ram_rdata & ~(BITMAP_WIDTH'(1) << hit_bit);
                        res_addr_next   = {pool_reg, OFFSET_W'(0)}
                                        + (ADDR_W'(hit_slot) << (MIN_SHIFT + int'(cls_reg)));
                        res_status_next = STATUS_DONE;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        // stray bit past the last slot: pool counts as full
                        state_next = ST_SCAN;
                    end
                end
                else if (word_inc < class_words)
                begin
                    word_next = word_inc[WORD_W-1:0];
                    ram_re    = 1'b1;
                    ram_raddr = {pool_reg, word_inc[WORD_W-1:0]};
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_CLAIM:
            begin
                // fill the new pool's words; slot 0 goes out at once
                ram_we    = 1'b1;
                ram_wdata = (word_reg == '0) ? {{(BITMAP_WIDTH-1){1'b1}}, 1'b0} : '1;
                if (word_reg == WORD_W'(WORDS_PER_POOL - 1))
                begin
                    res_addr_next   = {pool_reg, OFFSET_W'(0)};
                    res_status_next = STATUS_DONE;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    word_next = word_reg + WORD_W'(1);
                end
            end

            ST_FREE_WR:
            begin
                ram_we          = 1'b1;
                ram_wdata       = ram_rdata | (BITMAP_WIDTH'(1) << bit_reg);
                res_status_next = STATUS_DONE;
                state_next      = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    slot_address_next = res_addr_reg;
                    status_next       = res_status_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pools_in_use_reg <= '0;
            out_valid_reg    <= 1'b0;
            slot_address_reg <= '0;
            status_reg       <= STATUS_DONE;
            for (int i = 0; i < MAX_POOLS; i++)
            begin
                pool_tag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            pools_in_use_reg <= pools_in_use_next;
            out_valid_reg    <= out_valid_next;
            slot_address_reg <= slot_address_next;
            status_reg       <= status_next;
            if (tag_we)
            begin
                pool_tag_reg[pool_next] <= cls_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg          <= cls_next;
        scan_reg         <= scan_next;
        pool_reg         <= pool_next;
        word_reg         <= word_next;
        bit_reg          <= bit_next;
        res_addr_reg     <= res_addr_next;
        res_status_reg   <= res_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign slot_address = slot_address_reg;
    assign status       = status_reg;

    // pool count never runs past the region
    assert property (@(posedge clk) disable iff (!rst_n)
        pools_in_use_reg <= CNT_W'(MAX_POOLS))
        else $error("pool count exceeds region");

    // bitmap is written only while checking, claiming or freeing
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CHECK || state_reg == ST_CLAIM
                    || state_reg == ST_FREE_WR))
        else $error("bitmap write in wrong state");

    // a new result comes only out of the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("result without result state");

    // an allocated address lies in a claimed pool
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_DONE && slot_address_reg != '0)
        |-> ({1'b0, slot_address_reg[OFFSET_W +: POOL_W]} < pools_in_use_reg))
        else $error("address outside claimed pools");

endmodule

`default_nettype wire
